[src/nosc_pkg.sv]
// shared types, constants and helper functions for the natural-order compare
// no dependencies; imported by every module of the block
package nosc_pkg;

  localparam int MAX_LEN = 256;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int VAL_W   = 64;

  typedef logic [7:0]        char_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic signed [1:0] order_t;

  localparam order_t ORD_LT = 2'sb11;
  localparam order_t ORD_EQ = 2'sb00;
  localparam order_t ORD_GT = 2'sb01;

  localparam char_t CH_NUL  = 8'h00;
  localparam char_t CH_ZERO = 8'h30;
  localparam char_t CH_NINE = 8'h39;
  localparam char_t CH_UA   = 8'h41;
  localparam char_t CH_UZ   = 8'h5a;
  localparam char_t CH_LA   = 8'h61;
  localparam char_t CH_LZ   = 8'h7a;
  localparam char_t CASE_OFS = 8'h20;

  // controller to datapath
  typedef struct packed {
    logic start;   // reset walk pointers
    logic load;    // request accepted
    logic read;    // read both buffers at the walk pointers
    logic eval;    // evaluate the character pair
    logic numcmp;  // compare finished digit runs
    logic emit;    // move result to the output register, clear the pair
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic both_done;
    logic known;      // eval settled the order
    logic runs_end;   // both digit runs ended in eval
    logic num_known;  // numeric compare settled the order
  } status_t;

  function automatic logic is_digit(input char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_upper(input char_t c);
    return (c >= CH_UA) && (c <= CH_UZ);
  endfunction

  function automatic logic is_alnum(input char_t c);
    return is_digit(c) || is_upper(c) || ((c >= CH_LA) && (c <= CH_LZ));
  endfunction

  function automatic char_t to_lower(input char_t c);
    return is_upper(c) ? char_t'(c + CASE_OFS) : c;
  endfunction

  // v * 10 + d, saturating at all ones
  function automatic val_t dec_mac(input val_t v, input logic [3:0] d);
    logic [VAL_W+3:0] t;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{VAL_W{1'b0}}, d};
    return (t[VAL_W+3:VAL_W] != 4'd0) ? {VAL_W{1'b1}} : t[VAL_W-1:0];
  endfunction

endpackage

[src/nosc_ctrl.sv]
// controller state machine for the natural-order compare
// depends on nosc_pkg; drives commands into nosc_dp and the handshake flags
module nosc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  nosc_pkg::status_t st,
  output nosc_pkg::cmd_t    cmd
);
  import nosc_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_RD   = 5'b00010,
    S_EV   = 5'b00100,
    S_NC   = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_LOAD) || st.both_done;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_LOAD: begin
        cmd.load = in_valid && !in_stall;
        if (st.both_done) begin
          cmd.start = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.read  = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        cmd.eval = 1'b1;
        if (st.known) state_nxt = S_FIN;
        else if (st.runs_end) state_nxt = S_NC;
        else state_nxt = S_RD;
      end
      S_NC: begin
        cmd.numcmp = 1'b1;
        state_nxt  = st.num_known ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/nosc_dp.sv]
// datapath: string buffers, load counters, compare walk and result registers
// depends on nosc_pkg; steered by nosc_ctrl through cmd_t / status_t
module nosc_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  nosc_pkg::cmd_t    cmd,
  output nosc_pkg::status_t st,
  input  logic              in_which_string,
  input  logic [7:0]        in_character,
  input  logic              in_last,
  output logic signed [1:0] out_order,
  output logic              out_truncated
);
  import nosc_pkg::*;

  char_t mem1 [0:MAX_LEN-1];
  char_t mem2 [0:MAX_LEN-1];

  len_t   len1_r, len1_nxt, len2_r, len2_nxt;
  logic   done1_r, done1_nxt, done2_r, done2_nxt;
  logic   ovf_r, ovf_nxt;
  len_t   i_r, i_nxt, j_r, j_nxt;
  logic   dmode_r, dmode_nxt;
  logic   run1_r, run1_nxt, run2_r, run2_nxt;
  val_t   v1_r, v1_nxt, v2_r, v2_nxt;
  len_t   r1_r, r1_nxt, r2_r, r2_nxt;
  order_t res_r, res_nxt;
  char_t  rd1_r, rd2_r;
  logic   in1_r, in2_r;
  order_t out_order_r;
  logic   out_trunc_r;

  logic   wr1, wr2, room1, room2, nz;
  char_t  c1, c2, l1, l2;
  logic   dg1, dg2, al1, al2, act1, act2;

  assign nz    = in_character != CH_NUL;
  assign room1 = len1_r < len_t'(MAX_LEN);
  assign room2 = len2_r < len_t'(MAX_LEN);
  assign wr1   = cmd.load && !in_which_string && !done1_r && nz && room1;
  assign wr2   = cmd.load &&  in_which_string && !done2_r && nz && room2;

  // beyond the stored length a string reads as the terminator
  assign c1  = in1_r ? rd1_r : CH_NUL;
  assign c2  = in2_r ? rd2_r : CH_NUL;
  assign dg1 = is_digit(c1);
  assign dg2 = is_digit(c2);
  assign al1 = is_alnum(c1);
  assign al2 = is_alnum(c2);
  assign l1  = to_lower(c1);
  assign l2  = to_lower(c2);
  assign act1 = run1_r && dg1;
  assign act2 = run2_r && dg2;

  always_comb begin
    len1_nxt  = len1_r;
    len2_nxt  = len2_r;
    done1_nxt = done1_r;
    done2_nxt = done2_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    dmode_nxt = dmode_r;
    run1_nxt  = run1_r;
    run2_nxt  = run2_r;
    v1_nxt    = v1_r;
    v2_nxt    = v2_r;
    r1_nxt    = r1_r;
    r2_nxt    = r2_r;
    res_nxt   = res_r;
    st        = '0;
    st.both_done = done1_r && done2_r;

    if (cmd.load) begin
      if (!in_which_string && !done1_r) begin
        if (!nz) begin
          done1_nxt = 1'b1;
        end else begin
          if (room1) len1_nxt = len_t'(len1_r + 1'b1);
          else ovf_nxt = 1'b1;
          if (in_last) done1_nxt = 1'b1;
        end
      end
      if (in_which_string && !done2_r) begin
        if (!nz) begin
          done2_nxt = 1'b1;
        end else begin
          if (room2) len2_nxt = len_t'(len2_r + 1'b1);
          else ovf_nxt = 1'b1;
          if (in_last) done2_nxt = 1'b1;
        end
      end
    end

    if (cmd.start) begin
      i_nxt     = '0;
      j_nxt     = '0;
      dmode_nxt = 1'b0;
    end

    if (cmd.eval) begin
      if (dmode_r) begin
        if (act1) begin
          v1_nxt = dec_mac(v1_r, c1[3:0]);
          r1_nxt = len_t'(r1_r + 1'b1);
          i_nxt  = len_t'(i_r + 1'b1);
        end else begin
          run1_nxt = 1'b0;
        end
        if (act2) begin
          v2_nxt = dec_mac(v2_r, c2[3:0]);
          r2_nxt = len_t'(r2_r + 1'b1);
          j_nxt  = len_t'(j_r + 1'b1);
        end else begin
          run2_nxt = 1'b0;
        end
        st.runs_end = !act1 && !act2;
      end else if ((c1 == c2) && !dg1) begin
        if (c1 == CH_NUL) begin
          st.known = 1'b1;
          res_nxt  = ORD_EQ;
        end else begin
          i_nxt = len_t'(i_r + 1'b1);
          j_nxt = len_t'(j_r + 1'b1);
        end
      end else if (c1 == CH_NUL) begin
        st.known = 1'b1;
        res_nxt  = ORD_LT;
      end else if (c2 == CH_NUL) begin
        st.known = 1'b1;
        res_nxt  = ORD_GT;
      end else if (!al1 && al2) begin
        st.known = 1'b1;
        res_nxt  = ORD_LT;
      end else if (al1 && !al2) begin
        st.known = 1'b1;
        res_nxt  = ORD_GT;
      end else if (dg1 && dg2) begin
        // start both digit runs; the same pair is read again
        dmode_nxt = 1'b1;
        run1_nxt  = 1'b1;
        run2_nxt  = 1'b1;
        v1_nxt    = '0;
        v2_nxt    = '0;
        r1_nxt    = '0;
        r2_nxt    = '0;
      end else if ($signed(l1) < $signed(l2)) begin
        st.known = 1'b1;
        res_nxt  = ORD_LT;
      end else if ($signed(l1) > $signed(l2)) begin
        st.known = 1'b1;
        res_nxt  = ORD_GT;
      end else begin
        i_nxt = len_t'(i_r + 1'b1);
        j_nxt = len_t'(j_r + 1'b1);
      end
    end

    if (cmd.numcmp) begin
      dmode_nxt = 1'b0;
      st.num_known = 1'b1;
      // equal values: more leading zeros sorts first
      if (v1_r < v2_r) res_nxt = ORD_LT;
      else if (v1_r > v2_r) res_nxt = ORD_GT;
      else if (r1_r > r2_r) res_nxt = ORD_LT;
      else if (r2_r > r1_r) res_nxt = ORD_GT;
      else st.num_known = 1'b0;
    end

    if (cmd.emit) begin
      len1_nxt  = '0;
      len2_nxt  = '0;
      done1_nxt = 1'b0;
      done2_nxt = 1'b0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr1) mem1[len1_r[ADDR_W-1:0]] <= in_character;
    if (wr2) mem2[len2_r[ADDR_W-1:0]] <= in_character;
    if (cmd.read) begin
      rd1_r <= mem1[i_r[ADDR_W-1:0]];
      rd2_r <= mem2[j_r[ADDR_W-1:0]];
      in1_r <= i_r < len1_r;
      in2_r <= j_r < len2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len1_r  <= '0;
      len2_r  <= '0;
      done1_r <= 1'b0;
      done2_r <= 1'b0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      dmode_r <= 1'b0;
      run1_r  <= 1'b0;
      run2_r  <= 1'b0;
    end else begin
      len1_r  <= len1_nxt;
      len2_r  <= len2_nxt;
      done1_r <= done1_nxt;
      done2_r <= done2_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      dmode_r <= dmode_nxt;
      run1_r  <= run1_nxt;
      run2_r  <= run2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v1_r  <= v1_nxt;
    v2_r  <= v2_nxt;
    r1_r  <= r1_nxt;
    r2_r  <= r2_nxt;
    res_r <= res_nxt;
    if (cmd.emit) begin
      out_order_r <= res_r;
      out_trunc_r <= ovf_r;
    end
  end

  assign out_order     = out_order_r;
  assign out_truncated = out_trunc_r;

endmodule

[src/natural_order_string_compare.sv]
// top level of the natural-order string compare
// depends on nosc_pkg, nosc_ctrl and nosc_dp
//
//  channel  direction  ports                                       flow
//  in       sink       in_valid in_stall in_which_string           one char per request
//                      in_character in_last
//  out      source     out_valid out_stall out_order out_truncated one result per pair
//
// characters load while the controller is in its load state; after both strings end the walk
// starts, and each step reads both buffers then evaluates a character pair. a digit run pair
// is entered, stepped for each digit of the longer run and left, then its values are compared,
// and the result is posted. in_stall is high for the whole walk.
// synchronous reset clears lengths, flags and state; buffer contents are not cleared.
// a result waiting under out_stall holds the walk's end until it is taken.
module natural_order_string_compare (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_which_string,
  input  logic [7:0]        in_character,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [1:0] out_order,
  output logic              out_truncated
);
  import nosc_pkg::*;

  cmd_t    cmd;
  status_t st;

  nosc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  nosc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_which_string (in_which_string),
    .in_character    (in_character),
    .in_last         (in_last),
    .out_order       (out_order),
    .out_truncated   (out_truncated)
  );

  // no request taken once both strings have ended
  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !st.both_done)
    else $error("request accepted with both strings complete");

  // a posted result shows up on the output
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("result posted but out_valid low");

  // loading and walking never overlap
  a_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(cmd.eval || cmd.numcmp || cmd.read || cmd.emit))
    else $error("load overlaps compare walk");

endmodule
